>>> hw/rtl/ndd_pkg.sv
`timescale 1ns / 1ps

package ndd_pkg;

    localparam logic [1:0] MODE_CLEAR  = 2'd0;
    localparam logic [1:0] MODE_APPEND = 2'd1;
    localparam logic [1:0] MODE_EVAL   = 2'd2;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_EMPTY   = 3'd1;
    localparam logic [2:0] ST_EQUAL_X = 3'd2;
    localparam logic [2:0] ST_SAT     = 3'd3;
    localparam logic [2:0] ST_FULL    = 3'd4;

    typedef struct packed {
        logic [1:0]         mode;
        logic signed [31:0] node_x;
        logic signed [31:0] node_y;
        logic signed [31:0] eval_point;
    } cmd_t;

    typedef struct packed {
        logic signed [31:0] value;
        logic [2:0]         status;
    } res_t;

endpackage

>>> hw/rtl/newton_divided_difference_interp.sv
`timescale 1ns / 1ps
// Clear, append and unused-mode items: the result appears in the cycle after acceptance.
// Evaluate with valid coefficients: a Horner loop over the n nodes, each node taking
// a read, a start, 5 multiplier steps at 8 bits a cycle and a finish.
// After a change, the rebuild first copies the n ordinates (a read and a write each),
// then runs n*(n-1)/2 divisions by the bit-serial divider. One item at a time.
// Reset clears node count, coefficient state and the result valid flag; stores are not.
module newton_divided_difference_interp
    import ndd_pkg::*;
#(
    parameter int MAX_NODES = 16,
    parameter int FRAC_BITS = 16
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic cmd_valid,
    output logic cmd_stall,
    input  cmd_t cmd,
    output logic res_valid,
    input  logic res_stall,
    output res_t res
);

    localparam int IW = $clog2(MAX_NODES);
    localparam int CW = $clog2(MAX_NODES + 1);
    localparam int NW = 33 + FRAC_BITS;
    localparam logic [NW-1:0] QMIN_MAG = NW'(64'h8000_0000);
    localparam logic [NW-1:0] QMAX_MAG = NW'(64'h7FFF_FFFF);
    localparam logic signed [63:0] SMAX = 64'sh0000_0000_7FFF_FFFF;
    localparam logic signed [63:0] SMIN = -64'sh0000_0000_8000_0000;

    typedef enum logic [9:0] {
        S_IDLE   = 10'b00_0000_0001,
        S_CP_RD  = 10'b00_0000_0010,
        S_CP_WR  = 10'b00_0000_0100,
        S_DD_RD  = 10'b00_0000_1000,
        S_DD_CHK = 10'b00_0001_0000,
        S_DD_DIV = 10'b00_0010_0000,
        S_EV_RD  = 10'b00_0100_0000,
        S_EV_CHK = 10'b00_1000_0000,
        S_EV_MUL = 10'b01_0000_0000,
        S_DONE   = 10'b10_0000_0000
    } state_t;

    state_t state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic cvalid_reg, cvalid_next;
    logic sat_reg, sat_next;
    logic [IW-1:0] i_reg, i_next;
    logic [IW-1:0] j_reg, j_next;
    logic signed [31:0] xp_reg, xp_next;
    logic signed [31:0] t_reg, t_next;
    logic signed [31:0] a_reg, a_next;
    logic neg_reg, neg_next;
    res_t res_reg, res_next;
    logic res_valid_reg, res_valid_next;
    res_t pend_reg, pend_next;

    logic [31:0] x_mem [MAX_NODES];
    logic [31:0] y_mem [MAX_NODES];
    logic [31:0] c_mem [MAX_NODES];
    logic [31:0] xa_q, xb_q, y_q, ca_q, cb_q;
    logic [IW-1:0] xa_addr, xb_addr, y_addr, ca_addr, cb_addr;
    logic xy_we, c_we;
    logic [IW-1:0] xy_waddr, c_waddr;
    logic [31:0] c_wdata;

    logic div_start, div_done;
    logic [NW-1:0] div_num, div_quo;
    logic [32:0] div_den;
    logic mul_start, mul_done;
    logic [31:0] mul_a;
    logic [32:0] mul_b;
    logic [63:0] mul_prod;

    logic accept, out_free;
    logic [IW-1:0] cnt_m1;
    logic signed [32:0] num_s, den_s, d_s;
    logic signed [63:0] shifted, scaled, sum;
    logic signed [31:0] t_sat;
    logic sum_sat;
    logic [31:0] q_val;
    logic q_sat;

    ndd_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo)
    );

    ndd_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    always_ff @(posedge clk)
    begin
        if (xy_we)
        begin
            x_mem[xy_waddr] <= cmd.node_x;
            y_mem[xy_waddr] <= cmd.node_y;
        end
        if (c_we)
        begin
            c_mem[c_waddr] <= c_wdata;
        end
        xa_q <= x_mem[xa_addr];
        xb_q <= x_mem[xb_addr];
        y_q  <= y_mem[y_addr];
        ca_q <= c_mem[ca_addr];
        cb_q <= c_mem[cb_addr];
    end

    assign out_free  = !res_valid_reg || !res_stall;
    assign cmd_stall = (state_reg != S_IDLE) || !out_free;
    assign accept    = cmd_valid && !cmd_stall;
    assign cnt_m1    = IW'(count_reg - 1'b1);

    assign num_s   = {ca_q[31], ca_q} - {cb_q[31], cb_q};
    assign den_s   = {xa_q[31], xa_q} - {xb_q[31], xb_q};
    assign d_s     = {xp_reg[31], xp_reg} - {xa_q[31], xa_q};
    assign div_num = {(num_s[32] ? 33'(-num_s) : 33'(num_s)), {FRAC_BITS{1'b0}}};
    assign div_den = den_s[32] ? 33'(-den_s) : 33'(den_s);
    assign mul_a   = t_reg[31] ? 32'(-t_reg) : 32'(t_reg);
    assign mul_b   = d_s[32] ? 33'(-d_s) : 33'(d_s);

    // quotient magnitude back to a signed, saturated coefficient
    always_comb
    begin
        q_sat = 1'b0;
        if (neg_reg)
        begin
            if (div_quo > QMIN_MAG)
            begin
                q_sat = 1'b1;
                q_val = 32'h8000_0000;
            end
            else
            begin
                q_val = 32'(-div_quo[31:0]);
            end
        end
        else
        begin
            if (div_quo > QMAX_MAG)
            begin
                q_sat = 1'b1;
                q_val = 32'h7FFF_FFFF;
            end
            else
            begin
                q_val = div_quo[31:0];
            end
        end
    end

    // Horner step: truncate the product toward zero, add the coefficient, saturate
    always_comb
    begin
        shifted = $signed(mul_prod >> FRAC_BITS);
        scaled  = neg_reg ? -shifted : shifted;
        sum     = scaled + 64'(a_reg);
        sum_sat = 1'b0;
        if (sum > SMAX)
        begin
            sum_sat = 1'b1;
            t_sat   = 32'sh7FFF_FFFF;
        end
        else if (sum < SMIN)
        begin
            sum_sat = 1'b1;
            t_sat   = -32'sh8000_0000;
        end
        else
        begin
            t_sat = sum[31:0];
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        cvalid_next    = cvalid_reg;
        sat_next       = sat_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        xp_next        = xp_reg;
        t_next         = t_reg;
        a_next         = a_reg;
        neg_next       = neg_reg;
        pend_next      = pend_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg && res_stall;
        xa_addr        = '0;
        xb_addr        = '0;
        y_addr         = '0;
        ca_addr        = '0;
        cb_addr        = '0;
        xy_we          = 1'b0;
        xy_waddr       = count_reg[IW-1:0];
        c_we           = 1'b0;
        c_waddr        = j_reg;
        c_wdata        = y_q;
        div_start      = 1'b0;
        mul_start      = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    res_next.value  = '0;
                    res_next.status = ST_OK;
                    res_valid_next  = 1'b1;
                    case (cmd.mode)
                        MODE_CLEAR:
                        begin
                            count_next  = '0;
                            cvalid_next = 1'b0;
                        end
                        MODE_APPEND:
                        begin
                            if (count_reg >= CW'(MAX_NODES))
                            begin
                                res_next.status = ST_FULL;
                            end
                            else
                            begin
                                xy_we       = 1'b1;
                                count_next  = count_reg + 1'b1;
                                cvalid_next = 1'b0;
                            end
                        end
                        MODE_EVAL:
                        begin
                            if (count_reg == '0)
                            begin
                                res_next.status = ST_EMPTY;
                            end
                            else
                            begin
                                // hold the result back until the work is done
                                res_valid_next = res_valid_reg && res_stall;
                                xp_next  = cmd.eval_point;
                                sat_next = 1'b0;
                                if (cvalid_reg)
                                begin
                                    j_next     = cnt_m1;
                                    t_next     = '0;
                                    state_next = S_EV_RD;
                                end
                                else
                                begin
                                    j_next     = '0;
                                    state_next = S_CP_RD;
                                end
                            end
                        end
                        default:
                        begin
                            res_next.status = ST_OK;
                        end
                    endcase
                end
            end
            S_CP_RD:
            begin
                y_addr     = j_reg;
                state_next = S_CP_WR;
            end
            S_CP_WR:
            begin
                c_we = 1'b1;
                if (j_reg == cnt_m1)
                begin
                    i_next = IW'(1);
                    j_next = cnt_m1;
                    if (count_reg == CW'(1))
                    begin
                        cvalid_next = 1'b1;
                        t_next      = '0;
                        j_next      = cnt_m1;
                        state_next  = S_EV_RD;
                    end
                    else
                    begin
                        state_next = S_DD_RD;
                    end
                end
                else
                begin
                    j_next     = j_reg + 1'b1;
                    state_next = S_CP_RD;
                end
            end
            S_DD_RD:
            begin
                ca_addr    = j_reg;
                cb_addr    = j_reg - 1'b1;
                xa_addr    = j_reg;
                xb_addr    = j_reg - i_reg;
                state_next = S_DD_CHK;
            end
            S_DD_CHK:
            begin
                if (den_s == '0)
                begin
                    // equal abscissae: abandon the rebuild
                    pend_next.value  = '0;
                    pend_next.status = ST_EQUAL_X;
                    state_next       = S_DONE;
                end
                else
                begin
                    div_start  = 1'b1;
                    neg_next   = num_s[32] ^ den_s[32];
                    state_next = S_DD_DIV;
                end
            end
            S_DD_DIV:
            begin
                if (div_done)
                begin
                    c_we     = 1'b1;
                    c_wdata  = q_val;
                    sat_next = sat_reg | q_sat;
                    if (j_reg == i_reg)
                    begin
                        if (CW'(i_reg) + 1'b1 == count_reg)
                        begin
                            cvalid_next = 1'b1;
                            t_next      = '0;
                            j_next      = cnt_m1;
                            state_next  = S_EV_RD;
                        end
                        else
                        begin
                            i_next     = i_reg + 1'b1;
                            j_next     = cnt_m1;
                            state_next = S_DD_RD;
                        end
                    end
                    else
                    begin
                        j_next     = j_reg - 1'b1;
                        state_next = S_DD_RD;
                    end
                end
            end
            S_EV_RD:
            begin
                xa_addr    = j_reg;
                ca_addr    = j_reg;
                state_next = S_EV_CHK;
            end
            S_EV_CHK:
            begin
                mul_start  = 1'b1;
                neg_next   = t_reg[31] ^ d_s[32];
                a_next     = ca_q;
                state_next = S_EV_MUL;
            end
            S_EV_MUL:
            begin
                if (mul_done)
                begin
                    t_next   = t_sat;
                    sat_next = sat_reg | sum_sat;
                    if (j_reg == '0)
                    begin
                        pend_next.value  = t_sat;
                        pend_next.status = (sat_reg | sum_sat) ? ST_SAT : ST_OK;
                        state_next       = S_DONE;
                    end
                    else
                    begin
                        j_next     = j_reg - 1'b1;
                        state_next = S_EV_RD;
                    end
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    res_next       = pend_reg;
                    res_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            cvalid_reg    <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            cvalid_reg    <= cvalid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sat_reg  <= sat_next;
        i_reg    <= i_next;
        j_reg    <= j_next;
        xp_reg   <= xp_next;
        t_reg    <= t_next;
        a_reg    <= a_next;
        neg_reg  <= neg_next;
        pend_reg <= pend_next;
        res_reg  <= res_next;
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

>>> hw/rtl/ndd_div.sv
`timescale 1ns / 1ps

module ndd_div
    import ndd_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic [32+FRAC_BITS:0]   num,
    input  logic [32:0]             den,
    output logic                    done,
    output logic [32+FRAC_BITS:0]   quo
);

    localparam int NW = 33 + FRAC_BITS;
    localparam int CW = $clog2(NW + 1);

    logic [CW-1:0] cnt_reg, cnt_next;
    logic          run_reg, run_next;
    logic          done_reg, done_next;
    logic [32:0]   rem_reg, rem_next;
    logic [NW-1:0] quo_reg, quo_next;
    logic [32:0]   den_reg, den_next;
    logic [33:0]   trial;
    logic [33:0]   diff;

    assign trial = {rem_reg, quo_reg[NW-1]};
    assign diff  = trial - {1'b0, den_reg};

    always_comb
    begin
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        if (start)
        begin
            quo_next = num;
            den_next = den;
            rem_next = '0;
            cnt_next = CW'(NW);
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            // restoring step: shift in one dividend bit, subtract if it fits
            if (!diff[33])
            begin
                rem_next = diff[32:0];
                quo_next = {quo_reg[NW-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[32:0];
                quo_next = {quo_reg[NW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

>>> hw/rtl/ndd_mul.sv
`timescale 1ns / 1ps

module ndd_mul
    import ndd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] a,
    input  logic [32:0] b,
    output logic        done,
    output logic [63:0] prod
);

    localparam int STEPS = 5;

    logic [2:0]  cnt_reg, cnt_next;
    logic        run_reg, run_next;
    logic        done_reg, done_next;
    logic [31:0] a_reg, a_next;
    logic [39:0] b_reg, b_next;
    logic [63:0] acc_reg, acc_next;
    logic [39:0] part;

    assign part = a_reg * b_reg[39:32];

    always_comb
    begin
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        a_next    = a_reg;
        b_next    = b_reg;
        acc_next  = acc_reg;
        if (start)
        begin
            a_next   = a;
            b_next   = {7'd0, b};
            acc_next = '0;
            cnt_next = 3'(STEPS);
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            // take eight multiplier bits a cycle, most significant first
            acc_next = {acc_reg[55:0], 8'd0} + {24'd0, part};
            b_next   = {b_reg[31:0], 8'd0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == 3'd1)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        acc_reg <= acc_next;
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule

>>> bench/newton_divided_difference_interp_tb.sv
`timescale 1ns / 1ps

module newton_divided_difference_interp_tb;
    import ndd_pkg::*;

    localparam int NODES_MAX = 16;
    localparam int FRAC = 16;
    localparam longint LIMIT = 50000000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cmd_valid = 1'b0;
    logic cmd_stall;
    cmd_t cmd = '0;
    logic res_valid;
    logic res_stall = 1'b0;
    res_t res;

    newton_divided_difference_interp u_top (
        .clk(clk), .rst_n(rst_n),
        .cmd_valid(cmd_valid), .cmd_stall(cmd_stall), .cmd(cmd),
        .res_valid(res_valid), .res_stall(res_stall), .res(res)
    );

    always #1 clk = ~clk;

    // predictor state
    logic signed [31:0] xs [NODES_MAX];
    logic signed [31:0] ys [NODES_MAX];
    logic signed [31:0] coef [NODES_MAX];
    int unsigned node_cnt = 0;
    bit coef_ok = 0;

    cmd_t pending_items [$];
    res_t expected_results [$];
    int errors = 0;
    bit stim_done = 0;
    bit hold_sender = 0;
    int long_stall_left = 0;
    longint cycles = 0;

    function automatic logic signed [31:0] sat32(longint v, ref bit sat);
        if (v > 64'sd2147483647) begin
            sat = 1;
            return 32'sh7fffffff;
        end
        if (v < -64'sd2147483648) begin
            sat = 1;
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    function automatic bit rebuild_coefficients(ref bit sat);
        longint num;
        longint den;
        for (int i = 0; i < node_cnt; i++) coef[i] = ys[i];
        for (int i = 1; i < node_cnt; i++) begin
            for (int j = node_cnt - 1; j >= i; j--) begin
                num = longint'(coef[j]) - longint'(coef[j-1]);
                den = longint'(xs[j]) - longint'(xs[j-i]);
                if (den == 0) return 0;
                coef[j] = sat32((num * (64'sd1 <<< FRAC)) / den, sat);
            end
        end
        coef_ok = 1;
        return 1;
    endfunction

    function automatic res_t interpolate(cmd_t c);
        res_t r;
        bit sat;
        longint t;
        longint d;
        r = '0;
        r.status = ST_OK;
        sat = 0;
        if (c.mode == MODE_CLEAR) begin
            node_cnt = 0;
            coef_ok = 0;
        end else if (c.mode == MODE_APPEND) begin
            if (node_cnt >= NODES_MAX) r.status = ST_FULL;
            else begin
                xs[node_cnt] = c.node_x;
                ys[node_cnt] = c.node_y;
                node_cnt++;
                coef_ok = 0;
            end
        end else if (c.mode == MODE_EVAL) begin
            if (node_cnt == 0) r.status = ST_EMPTY;
            else if (!coef_ok && !rebuild_coefficients(sat)) r.status = ST_EQUAL_X;
            else begin
                t = 0;
                for (int i = node_cnt - 1; i >= 0; i--) begin
                    d = longint'(c.eval_point) - longint'(xs[i]);
                    t = sat32((t * d) / (64'sd1 <<< FRAC) + longint'(coef[i]), sat);
                end
                r.value = t[31:0];
                if (sat) r.status = ST_SAT;
            end
        end
        return r;
    endfunction

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 5))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return $urandom();
            default: return $signed($urandom_range(0, 20 << FRAC)) - (10 << FRAC);
        endcase
    endfunction

    function automatic cmd_t make_item(logic [1:0] m, logic [31:0] x, logic [31:0] y,
                                       logic [31:0] p);
        cmd_t c;
        c.mode = m;
        c.node_x = x;
        c.node_y = y;
        c.eval_point = p;
        return c;
    endfunction

    function automatic void add_item(cmd_t c);
        pending_items = {pending_items, c};
    endfunction

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    initial begin
        int n;
        int burst;
        cmd_t c;
        bit paused;
        paused = 0;
        repeat (3) @(posedge clk);
        @(negedge clk) rst_n = 1'b1;

        // directed: empty evaluate, unused mode, extremes, equal x, full store
        add_item(make_item(MODE_EVAL, 0, 0, 0));
        add_item(make_item(MODE_UNUSED, 32'hffffffff, 32'hffffffff, 32'hffffffff));
        add_item(make_item(MODE_APPEND, 32'h80000000, 32'h7fffffff, 0));
        add_item(make_item(MODE_APPEND, 32'h7fffffff, 32'h80000000, 0));
        add_item(make_item(MODE_EVAL, 0, 0, 32'h7fffffff));
        add_item(make_item(MODE_EVAL, 0, 0, 32'h80000000));
        add_item(make_item(MODE_APPEND, 32'h7fffffff, 5, 0));
        add_item(make_item(MODE_EVAL, 0, 0, 1));
        add_item(make_item(MODE_EVAL, 0, 0, 2));
        add_item(make_item(MODE_CLEAR, 32'hffffffff, 32'hffffffff, 32'hffffffff));
        for (int i = 0; i < 17; i++)
            add_item(make_item(MODE_APPEND, i << FRAC, (i * i) << FRAC, 0));
        add_item(make_item(MODE_EVAL, 0, 0, 32'h00028000));
        add_item(make_item(MODE_CLEAR, 0, 0, 0));

        // random: usually a clear, a few nodes (mostly few, seldom many), some evaluations or unused-mode items
        n = 0;
        while (n < 1750) begin
            if ($urandom_range(0, 9) < 8)
                add_item(make_item(MODE_CLEAR, rand_word(), rand_word(), rand_word()));
            burst = ($urandom_range(0, 19) == 0) ? $urandom_range(8, 17)
                                                 : $urandom_range(1, 4);
            for (int i = 0; i < burst; i++) begin
                c = make_item(MODE_APPEND, rand_word(), rand_word(), rand_word());
                if ($urandom_range(0, 9) != 0) c.node_x = ($urandom_range(0, 255) << 12)
                                                          - (128 << 12) + i;
                add_item(c);
            end
            for (int i = $urandom_range(1, 4); i > 0; i--) begin
                c = make_item(($urandom_range(0, 19) == 0) ? MODE_UNUSED : MODE_EVAL,
                              rand_word(), rand_word(), rand_word());
                add_item(c);
            end
            n += burst + 3;
            if (n > 600 && !paused) begin
                // pause sender until drained
                paused = 1;
                wait (pending_items.size() == 0 && !cmd_valid);
                hold_sender = 1;
                wait (expected_results.size() == 0);
                @(negedge clk) hold_sender = 0;
            end
        end
        wait (pending_items.size() == 0 && !cmd_valid);
        wait (expected_results.size() == 0);
        repeat (200) @(posedge clk);
        stim_done = 1;
    end

    // accept sampled at the rising edge
    logic cmd_stall_seen = 1'b0;
    always @(posedge clk) begin
        cmd_stall_seen <= cmd_stall;
        if (cmd_valid && !cmd_stall)
            expected_results = {expected_results, interpolate(cmd)};
    end

    int send_gap = 0;
    always @(negedge clk) begin
        if (rst_n) begin
            if (cmd_valid && !cmd_stall_seen) begin
                // item taken: send the next one at once or drop valid for a gap
                send_gap = gap_len();
                if (send_gap == 0 && pending_items.size() > 0 && !hold_sender) begin
                    cmd <= pending_items.pop_front();
                    cmd_valid <= 1'b1;
                end else begin
                    cmd_valid <= 1'b0;
                end
            end else if (!cmd_valid && !hold_sender) begin
                if (send_gap > 0) send_gap--;
                else if (pending_items.size() > 0) begin
                    cmd <= pending_items.pop_front();
                    cmd_valid <= 1'b1;
                end
            end
        end
    end

    int recv_gap = 0;
    bit long_done = 0;
    always @(negedge clk) begin
        if (rst_n) begin
            if (!long_done && pending_items.size() < 900 && pending_items.size() > 0) begin
                long_done = 1;
                long_stall_left = 3000;
            end
            if (long_stall_left > 0) begin
                long_stall_left--;
                res_stall <= 1'b1;
            end else if (recv_gap > 0) begin
                recv_gap--;
                res_stall <= 1'b1;
            end else begin
                res_stall <= 1'b0;
                recv_gap = ($urandom_range(0, 3) == 0) ? gap_len() : 0;
            end
        end
    end

    always @(posedge clk) begin
        res_t want;
        cycles++;
        if (res_valid && !res_stall && rst_n) begin
            if (expected_results.size() == 0) begin
                errors++;
                $display("%0t: unexpected result value=%h status=%0d", $time,
                         res.value, res.status);
            end else begin
                want = expected_results.pop_front();
                if (res.value !== want.value) begin
                    errors++;
                    $display("%0t: value expected %h actual %h", $time, want.value,
                             res.value);
                end
                if (res.status !== want.status) begin
                    errors++;
                    $display("%0t: status expected %0d actual %0d", $time, want.status,
                             res.status);
                end
            end
        end
        if (stim_done) begin
            if (errors == 0 && expected_results.size() == 0)
                $display("Test completed successfully");
            else
                $display("Test completed with failures");
            $finish;
        end else if (cycles > LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

endmodule
